// ----- src/grf_pkg.sv -----
// shared constants and types of the grid rectangle first-fit unit
package grf_pkg;

  localparam int MAX_ROWS     = 8;
  localparam int MAX_COLS     = 8;
  localparam int MAX_RECT_DIM = 4;
  localparam int OWNER_BITS   = 16;

  localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int MAX_DIM    = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int CW         = $clog2(MAX_DIM + 16);

  localparam int OWNER_W   = 16;
  localparam int RDIM_W    = 3;
  localparam int GDIM_W    = 4;
  localparam int INDEX_W   = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

  localparam logic [OWNER_BITS-1:0] OWNER_EMPTY = {OWNER_BITS{1'b1}};

  typedef struct packed {
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [OWNER_BITS-1:0] wr_data;
  } cell_req_t;

endpackage

// ----- src/grid_rectangle_first_fit_unit.sv -----
// top level of the grid rectangle first-fit unit
// A request places a rect_width x rect_height rectangle for owner_id in an
// 8 x 8 occupancy grid, first fit in row-major order of top-left corners.
// The unit takes one request at a time; the next request is taken once the
// last result of the previous one sits in the output register. Each cell
// test is a read state and a check state, because the grid lives in a
// memory with one read port and registered read data; each claimed cell then
// takes a claim step, and a stalled output holds the claim or not-found
// step. The worst case is a full scan of all window positions with a late
// miss in each. Requests with a bad size or the empty owner skip the scan and
// answer not found. The grid reads empty right after reset with no clearing
// pass. Configuration writes are always taken and should only be made while
// the unit is idle.
module grid_rectangle_first_fit_unit
  import grf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [GDIM_W-1:0]    cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,   // owner_id, rect_width, rect_height
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // found, cell_index
  output logic                 m_axis_tlast
);

  logic [GDIM_W-1:0]  grid_rows_q, grid_cols_q;
  logic               res_found;
  logic [INDEX_W-1:0] res_index;
  cell_req_t          ram_req;
  logic               rd_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= GDIM_W'(8);
      grid_cols_q <= GDIM_W'(8);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GRID_ROWS: grid_rows_q <= cfg_data_i;
        REG_GRID_COLS: grid_cols_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  grf_scan_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .grid_rows_i   (grid_rows_q),
    .grid_cols_i   (grid_cols_q),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (s_axis_tready),
    .owner_id_i    (s_axis_tdata[15:0]),
    .rect_width_i  (s_axis_tdata[18:16]),
    .rect_height_i (s_axis_tdata[21:19]),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_found_o   (res_found),
    .res_index_o   (res_index),
    .res_last_o    (m_axis_tlast),
    .ram_req_o     (ram_req),
    .rd_empty_i    (rd_empty)
  );

  grf_cell_ram u_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (ram_req),
    .rd_empty_o (rd_empty)
  );

  assign m_axis_tdata = {1'b0, res_index, res_found};

endmodule

// ----- src/grf_cell_ram.sv -----
// occupancy memory with per-entry valid bits, registered read
module grf_cell_ram
  import grf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_req_t req_i,
  output logic      rd_empty_o
);

  logic [OWNER_BITS-1:0] mem [CELL_COUNT];
  logic [OWNER_BITS-1:0] rd_data_q;
  logic [CELL_COUNT-1:0] vld_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_empty_o = !rd_vld_q || (rd_data_q == OWNER_EMPTY);

endmodule

// ----- src/grf_scan_ctrl.sv -----
// window scan sequencer, claim write-back and result register
module grf_scan_ctrl
  import grf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [GDIM_W-1:0]  grid_rows_i,
  input  logic [GDIM_W-1:0]  grid_cols_i,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  logic [OWNER_W-1:0] owner_id_i,
  input  logic [RDIM_W-1:0]  rect_width_i,
  input  logic [RDIM_W-1:0]  rect_height_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic               res_found_o,
  output logic [INDEX_W-1:0] res_index_o,
  output logic               res_last_o,
  output cell_req_t          ram_req_o,
  input  logic               rd_empty_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_CLM  = 3'd3;
  localparam logic [2:0] ST_NF   = 3'd4;

  localparam logic [CW-1:0] ONE = CW'(1);

  logic [2:0]            state_q, state_d;
  logic [OWNER_BITS-1:0] owner_q, owner_d;
  logic [CW-1:0]         w_q, w_d, h_q, h_d, rows_q, rows_d, cols_q, cols_d;
  logic [CW-1:0]         r0_q, r0_d, c0_q, c0_d, dr_q, dr_d, dc_q, dc_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_found_q, out_found_d;
  logic [INDEX_W-1:0]    out_index_q, out_index_d;
  logic                  out_last_q, out_last_d;

  logic [CW-1:0]         cur_r, cur_c, in_w, in_h, in_rows, in_cols;
  logic [ADDR_W-1:0]     cur_addr;
  logic [2*CW-1:0]       lin_index;
  logic [OWNER_BITS-1:0] in_owner;
  logic                  slot_free, in_ok, win_last;

  assign cur_r     = r0_q + dr_q;
  assign cur_c     = c0_q + dc_q;
  assign cur_addr  = ADDR_W'(32'(cur_r) * MAX_COLS + 32'(cur_c));
  assign lin_index = (2*CW)'(cur_r) * (2*CW)'(cols_q) + (2*CW)'(cur_c);
  assign slot_free = !out_valid_q || res_ready_i;
  assign win_last  = (dr_q + ONE == h_q) && (dc_q + ONE == w_q);

  assign in_owner = OWNER_BITS'(owner_id_i);
  assign in_w     = CW'(rect_width_i);
  assign in_h     = CW'(rect_height_i);
  assign in_rows  = (32'(grid_rows_i) > MAX_ROWS) ? CW'(MAX_ROWS) : CW'(grid_rows_i);
  assign in_cols  = (32'(grid_cols_i) > MAX_COLS) ? CW'(MAX_COLS) : CW'(grid_cols_i);
  assign in_ok    = (in_w != '0) && (in_h != '0) &&
                    (32'(in_w) <= MAX_RECT_DIM) && (32'(in_h) <= MAX_RECT_DIM) &&
                    (in_owner != OWNER_EMPTY) && (in_h <= in_rows) && (in_w <= in_cols);

  always_comb begin
    state_d     = state_q;
    owner_d     = owner_q;
    w_d         = w_q;
    h_d         = h_q;
    rows_d      = rows_q;
    cols_d      = cols_q;
    r0_d        = r0_q;
    c0_d        = c0_q;
    dr_d        = dr_q;
    dc_d        = dc_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_found_d = out_found_q;
    out_index_d = out_index_q;
    out_last_d  = out_last_q;
    req_ready_o = 1'b0;
    ram_req_o   = '{rd_en: 1'b0, rd_addr: cur_addr, wr_en: 1'b0,
                    wr_addr: cur_addr, wr_data: owner_q};
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          owner_d = in_owner;
          w_d     = in_w;
          h_d     = in_h;
          rows_d  = in_rows;
          cols_d  = in_cols;
          r0_d    = '0;
          c0_d    = '0;
          dr_d    = '0;
          dc_d    = '0;
          state_d = in_ok ? ST_RD : ST_NF;
        end
      end
      ST_RD: begin
        ram_req_o.rd_en = 1'b1;
        state_d         = ST_CHK;
      end
      ST_CHK: begin
        state_d = ST_RD;
        if (rd_empty_i) begin
          if (dc_q + ONE < w_q) begin
            dc_d = dc_q + ONE;
          end else if (dr_q + ONE < h_q) begin
            dr_d = dr_q + ONE;
            dc_d = '0;
          end else begin
            dr_d    = '0;
            dc_d    = '0;
            state_d = ST_CLM;
          end
        end else begin
          dr_d = '0;
          dc_d = '0;
          if (c0_q + ONE + w_q <= cols_q) begin
            c0_d = c0_q + ONE;
          end else if (r0_q + ONE + h_q <= rows_q) begin
            r0_d = r0_q + ONE;
            c0_d = '0;
          end else begin
            state_d = ST_NF;
          end
        end
      end
      ST_CLM: begin
        if (slot_free) begin
          ram_req_o.wr_en = 1'b1;
          out_valid_d     = 1'b1;
          out_found_d     = 1'b1;
          out_index_d     = lin_index[INDEX_W-1:0];
          out_last_d      = win_last;
          if (win_last) begin
            state_d = ST_IDLE;
          end else if (dc_q + ONE < w_q) begin
            dc_d = dc_q + ONE;
          end else begin
            dc_d = '0;
            dr_d = dr_q + ONE;
          end
        end
      end
      ST_NF: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_found_d = 1'b0;
          out_index_d = '0;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    owner_q     <= owner_d;
    w_q         <= w_d;
    h_q         <= h_d;
    rows_q      <= rows_d;
    cols_q      <= cols_d;
    r0_q        <= r0_d;
    c0_q        <= c0_d;
    dr_q        <= dr_d;
    dc_q        <= dc_d;
    out_found_q <= out_found_d;
    out_index_q <= out_index_d;
    out_last_q  <= out_last_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_found_o = out_found_q;
  assign res_index_o = out_index_q;
  assign res_last_o  = out_last_q;

endmodule

// ----- src/grf_checker.sv -----
// port-level checks of the grid rectangle first-fit unit
module grf_checker
  import grf_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_not_found_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tlast && (m_axis_tdata[6:1] == '0))
    else $error("malformed not-found result");

  a_busy_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("request taken during a result run");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken back to back");

endmodule

bind grid_rectangle_first_fit_unit grf_checker u_grf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- verif/grid_rectangle_first_fit_unit_tb.sv -----
// testbench of the grid rectangle first-fit unit, checked against an occupancy model
`timescale 1ns / 100ps
module grid_rectangle_first_fit_unit_tb;
  import grf_pkg::*;

  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_PRINTS    = 30;
  localparam int PHASE_ITEMS   = 46;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] index;
    logic               last;
  } cell_claim_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [GDIM_W-1:0]    cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata;   // owner_id, rect_width, rect_height
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [7:0]           m_axis_tdata;   // found, cell_index
  logic                 m_axis_tlast;

  logic [OWNER_BITS-1:0] occ_grid [CELL_COUNT];
  logic [GDIM_W-1:0]     rows_in_use;
  logic [GDIM_W-1:0]     cols_in_use;
  cell_claim_t           claim_q [$];

  int src_idle_pct  = 27;
  int sink_idle_pct = 27;
  int hold_cycles   = 0;
  int mismatch_cnt  = 0;
  int stall_cnt     = 0;
  int req_cnt       = 0;
  int claimed_cnt   = 0;
  int miss_cnt      = 0;
  int grid_cnt      = 0;

  grid_rectangle_first_fit_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // first-fit scan over the grid in use, claims the window and queues one result per cell, or one not-found result
  function automatic void predict_placement(input logic [OWNER_BITS-1:0] owner,
                                            input logic [RDIM_W-1:0] w,
                                            input logic [RDIM_W-1:0] h);
    int          rows;
    int          cols;
    int          wd;
    int          ht;
    bit          hit;
    bit          fits;
    cell_claim_t claim;
    rows = (int'(rows_in_use) > MAX_ROWS) ? MAX_ROWS : int'(rows_in_use);
    cols = (int'(cols_in_use) > MAX_COLS) ? MAX_COLS : int'(cols_in_use);
    wd   = int'(w);
    ht   = int'(h);
    hit  = 1'b0;
    if (wd != 0 && ht != 0 && wd <= MAX_RECT_DIM && ht <= MAX_RECT_DIM &&
        owner != OWNER_EMPTY && ht <= rows && wd <= cols) begin
      for (int r0 = 0; r0 + ht <= rows && !hit; r0++) begin
        for (int c0 = 0; c0 + wd <= cols && !hit; c0++) begin
          fits = 1'b1;
          for (int r = r0; r < r0 + ht; r++)
            for (int c = c0; c < c0 + wd; c++)
              if (occ_grid[r * MAX_COLS + c] != OWNER_EMPTY) fits = 1'b0;
          if (fits) begin
            hit = 1'b1;
            for (int r = r0; r < r0 + ht; r++) begin
              for (int c = c0; c < c0 + wd; c++) begin
                occ_grid[r * MAX_COLS + c] = owner;
                claim.found = 1'b1;
                claim.index = INDEX_W'(r * cols + c);
                claim.last  = (r == r0 + ht - 1) && (c == c0 + wd - 1);
                claim_q.push_back(claim);
                claimed_cnt++;
              end
            end
          end
        end
      end
    end
    if (!hit) begin
      claim.found = 1'b0;
      claim.index = '0;
      claim.last  = 1'b1;
      claim_q.push_back(claim);
      miss_cnt++;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTS)
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin : result_monitor
    cell_claim_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_GRID_ROWS) rows_in_use = cfg_data_i;
        else cols_in_use = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_placement(s_axis_tdata[15:0], s_axis_tdata[18:16], s_axis_tdata[21:19]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (claim_q.size() == 0) begin
          report_mismatch("result with no request pending, tdata", int'(m_axis_tdata), 0);
        end else begin
          want = claim_q.pop_front();
          if (m_axis_tdata[0] !== want.found)
            report_mismatch("found", int'(m_axis_tdata[0]), int'(want.found));
          if (m_axis_tdata[6:1] !== want.index)
            report_mismatch("cell_index", int'(m_axis_tdata[6:1]), int'(want.index));
          if (m_axis_tlast !== want.last)
            report_mismatch("last", int'(m_axis_tlast), int'(want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // result receiver, with an optional long hold-off counted here
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  task automatic send_request(input logic [OWNER_BITS-1:0] owner,
                              input logic [RDIM_W-1:0] w,
                              input logic [RDIM_W-1:0] h);
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, h, w, owner};
    do @(posedge clk_i); while (!s_axis_tready);
    req_cnt++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (claim_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GDIM_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_grid(input logic [GDIM_W-1:0] rows, input logic [GDIM_W-1:0] cols);
    wait_idle();
    write_reg(REG_GRID_ROWS, rows);
    write_reg(REG_GRID_COLS, cols);
    grid_cnt++;
  endtask

  function automatic logic [RDIM_W-1:0] pick_dim();
    if ($urandom_range(0, 99) < 8) return RDIM_W'($urandom_range(0, 7));
    if ($urandom_range(0, 99) < 70) return RDIM_W'($urandom_range(1, 2));
    return RDIM_W'($urandom_range(1, MAX_RECT_DIM));
  endfunction

  function automatic logic [OWNER_BITS-1:0] pick_owner();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return OWNER_EMPTY;
    if (roll < 6) return '0;
    return OWNER_BITS'($urandom_range(0, 16'hfffe));
  endfunction

  task automatic test_request_fields();
    send_request(16'h0000, 3'd1, 3'd1);
    send_request(16'h1234, 3'd4, 3'd4);
    // bad sizes and the empty owner change nothing
    send_request(16'h00ff, 3'd0, 3'd1);
    send_request(16'h0f0f, 3'd1, 3'd0);
    send_request(16'h5a5a, 3'd5, 3'd2);
    send_request(16'ha5a5, 3'd2, 3'd7);
    send_request(16'h7777, 3'd7, 3'd7);
    send_request(OWNER_EMPTY, 3'd1, 3'd1);
  endtask

  task automatic test_grid_sizes();
    set_grid(4'd0, 4'd8);
    send_request(16'h0011, 3'd1, 3'd1);
    set_grid(4'd8, 4'd0);
    send_request(16'h0012, 3'd1, 3'd1);
    set_grid(4'd0, 4'd0);
    send_request(16'h0013, 3'd1, 3'd1);
    // oversized values saturate to the full grid
    set_grid(4'd15, 4'd9);
    send_request(16'hfffe, 3'd4, 3'd4);
    set_grid(4'd1, 4'd3);
    send_request(16'h0042, 3'd4, 3'd1);
    send_request(16'h0043, 3'd1, 3'd2);
    send_request(16'h0044, 3'd3, 3'd1);
    set_grid(4'd8, 4'd5);
    send_request(16'h0101, 3'd2, 3'd3);
    send_request(16'h0102, 3'd1, 3'd1);
    set_grid(4'd1, 4'd1);
    send_request(16'h0103, 3'd1, 3'd1);
  endtask

  task automatic test_output_backpressure();
    set_grid(4'd8, 4'd8);
    hold_cycles = 400;
    repeat (12) send_request(pick_owner(), RDIM_W'($urandom_range(1, 2)),
                             RDIM_W'($urandom_range(1, 2)));
  endtask

  task automatic test_random_placement();
    for (int p = 0; p < 10; p++) begin
      if (p == 6) set_grid(4'd15, 4'd15);
      else set_grid(GDIM_W'($urandom_range(1, 2 + p)), GDIM_W'($urandom_range(1, 2 + p)));
      src_idle_pct  = (p == 5) ? 0 : 27;
      sink_idle_pct = (p == 5) ? 0 : 27;
      repeat (PHASE_ITEMS) send_request(pick_owner(), pick_dim(), pick_dim());
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_GRID_ROWS;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    for (int i = 0; i < CELL_COUNT; i++) occ_grid[i] = OWNER_EMPTY;
    rows_in_use = 4'd8;
    cols_in_use = 4'd8;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_request_fields();
    test_grid_sizes();
    test_output_backpressure();
    test_random_placement();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (claim_q.size() != 0) report_mismatch("results still pending", 0, claim_q.size());
    $display("covered %0d placement requests over %0d grid settings", req_cnt, grid_cnt);
    $display("%0d cells claimed, %0d requests not placed, %0d mismatches",
             claimed_cnt, miss_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/grf_pkg.sv
src/grf_cell_ram.sv
src/grf_scan_ctrl.sv
src/grid_rectangle_first_fit_unit.sv
src/grf_checker.sv
verif/grid_rectangle_first_fit_unit_tb.sv
